### sv/tsavg_pkg.sv
// Shared constants and types of the averaged temperature sensor core.
package tsavg_pkg;

  // Default number of history entries in the moving average.
  localparam int unsigned HistDepthDef = 8;

  // Width of one converted temperature in 1/16 degree units.
  localparam int unsigned TempW = 16;
  // Width of the averaged result in 1/256 degree units.
  localparam int unsigned AvgW = 20;
  // Widths of the stream payloads, padded to whole bytes.
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 24;

  // APB address width and register map.
  localparam int unsigned PaddrW = 3;
  localparam logic [PaddrW-1:0] AddrFamily = 3'd0;

  // Count-remain refinement constants of the nine-bit sensor family.
  localparam logic [7:0] CountPerDegFine = 8'h10;
  localparam logic [TempW-1:0] FineMask = 16'hFFF0;
  localparam logic [TempW-1:0] FineOffset = 16'd12;

  // Resolution field in bits 6:5 of the sensor config byte.
  typedef enum logic [1:0] {
    RES_9BIT  = 2'b00,
    RES_10BIT = 2'b01,
    RES_11BIT = 2'b10,
    RES_12BIT = 2'b11
  } res_sel_e;

endpackage

### sv/temp_sensor_scratchpad_average_core.sv
// Top level: scratchpad conversion and moving average of a one-wire sensor.
//
// One input transfer carries one finished scratchpad read: tdata holds the
// temperature bytes, the config byte and both count bytes, tuser the read
// error flag. The core turns the bytes into a signed temperature in 1/16
// degree, writes it into a circular history held in a small RAM, and
// returns the mean of the whole history in 1/256 degree on the output
// stream. A transfer with the error flag set leaves the history alone and
// yields a zero mean with the error flag set in tuser.
// The core takes one item per cycle while the output is not stalled. An item
// passes the stages in order: RAM read, running-sum update, offset add,
// reciprocal multiply, then the output register. The history RAM is read
// once per item and written once per item without a read error; a write
// and a read of the same entry in one cycle are resolved by forwarding.
// Each stage holds only while the stage after it is full and stalled, so
// a stalled output fills the pipeline before the input side drops tready.
// Reset clears the running sum, the write pointer, the entry valid bits
// (unwritten entries count as zero) and the family register. The APB port
// holds one register at address 0: bit 0 selects the nine-bit family.
module temp_sensor_scratchpad_average_core #(
  parameter int unsigned HISTORY_DEPTH = tsavg_pkg::HistDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tsavg_pkg::PaddrW-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: temp_lsb[7:0], temp_msb[15:8], resolution_byte[23:16],
  //        count_remain[31:24], count_per_degree[39:32]
  input  logic [tsavg_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: read_error[0]
  input  logic                             s_axis_tuser,
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: average_temp[19:0], zero fill [23:20]
  output logic [tsavg_pkg::OutDataW-1:0]   m_axis_tdata,
  // tuser: error_flag[0]
  output logic                             m_axis_tuser
);

  localparam int unsigned TempW = tsavg_pkg::TempW;
  localparam int unsigned AvgW = tsavg_pkg::AvgW;
  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned Lg = $clog2(HISTORY_DEPTH);
  // Running sum, sum times 16, biased dividend and reciprocal shift.
  localparam int unsigned SumW = TempW + Lg;
  localparam int unsigned NumW = SumW + 4;
  localparam int unsigned MW = NumW + Lg;
  localparam int unsigned K = MW + Lg;
  localparam logic [AW-1:0] LastIdx = AW'(HISTORY_DEPTH - 1);
  // Reciprocal ceil(2^K / depth) gives an exact floor quotient below 2^MW.
  localparam logic [63:0] RecipWide =
    ((64'd1 << K) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
  localparam logic [MW:0] Recip = RecipWide[MW:0];
  // Bias of depth * 2^(NumW-1) keeps the dividend non-negative.
  localparam logic [63:0] BiasWide = 64'(HISTORY_DEPTH) << (NumW - 1);
  localparam logic [MW-1:0] Bias = BiasWide[MW-1:0];
  // The bias shows up as 2^(NumW-1) in the quotient.
  localparam logic [63:0] OutOffWide = 64'd1 << (NumW - 1);
  localparam logic [AvgW-1:0] OutOff = OutOffWide[AvgW-1:0];

  // Configuration register.
  logic family_q;
  logic cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr == tsavg_pkg::AddrFamily) ? {31'd0, family_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q <= 1'b0;
    end else if (cfg_wr && (paddr == tsavg_pkg::AddrFamily)) begin
      family_q <= pwdata[0];
    end
  end

  // Stage load enables: a stage loads when it is empty or its content moves on.
  logic v1_q, v2_q, v3_q, v4_q, ov_q;
  logic ld1, ld2, ld3, ld4, ld_out;
  logic accept;

  assign ld_out = !ov_q || m_axis_tready;
  assign ld4 = !v4_q || ld_out;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;
  assign s_axis_tready = ld1;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Scratchpad conversion to 1/16 degree.
  logic [7:0] temp_lsb, temp_msb, resolution_byte, count_remain, count_per_degree;
  logic [TempW-1:0] raw, raw_x8, conv;

  assign temp_lsb = s_axis_tdata[7:0];
  assign temp_msb = s_axis_tdata[15:8];
  assign resolution_byte = s_axis_tdata[23:16];
  assign count_remain = s_axis_tdata[31:24];
  assign count_per_degree = s_axis_tdata[39:32];
  assign raw = {temp_msb, temp_lsb};
  assign raw_x8 = raw << 3;

  always_comb begin
    conv = raw;
    if (family_q) begin
      if (count_per_degree == tsavg_pkg::CountPerDegFine) begin
        conv = (raw_x8 & tsavg_pkg::FineMask) + tsavg_pkg::FineOffset
               - TempW'(count_remain);
      end else begin
        conv = raw_x8;
      end
    end else begin
      case (tsavg_pkg::res_sel_e'(resolution_byte[6:5]))
        tsavg_pkg::RES_9BIT:  conv = raw_x8;
        tsavg_pkg::RES_10BIT: conv = raw << 2;
        tsavg_pkg::RES_11BIT: conv = raw << 1;
        tsavg_pkg::RES_12BIT: conv = raw;
        default:              conv = raw;
      endcase
    end
  end

  // Write pointer and entry valid bits.
  logic [AW-1:0] wp_q;
  logic [HISTORY_DEPTH-1:0] ent_vld_q;
  logic wr_en;
  logic [AW-1:0] wp1_q;
  logic signed [TempW-1:0] val1_q;
  logic err1_q;

  assign wr_en = ld2 && v1_q && !err1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      ent_vld_q <= '0;
    end else begin
      if (accept && !s_axis_tuser) begin
        wp_q <= (wp_q == LastIdx) ? '0 : wp_q + AW'(1);
      end
      if (wr_en) begin
        ent_vld_q[wp1_q] <= 1'b1;
      end
    end
  end

  // History RAM: read the entry to be replaced at accept, write the new value later.
  logic [TempW-1:0] rdata;

  tsavg_ram #(
    .Width (TempW),
    .Depth (HISTORY_DEPTH),
    .AddrW (AW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wp1_q),
    .wdata_i (val1_q),
    .re_i    (accept),
    .raddr_i (wp_q),
    .rdata_o (rdata)
  );

  // Stage 1: converted value, read in flight, forwarding of a same-entry write.
  logic fwd1_q, ent_vld1_q;
  logic signed [TempW-1:0] fwd_data1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ld1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val1_q <= conv;
      err1_q <= s_axis_tuser;
      wp1_q <= wp_q;
      ent_vld1_q <= ent_vld_q[wp_q];
      fwd1_q <= wr_en && (wp1_q == wp_q);
      fwd_data1_q <= val1_q;
    end
  end

  // Stage 2: running-sum update, old entry from forwarding, RAM or reset value.
  logic signed [TempW-1:0] old_val;
  logic signed [SumW-1:0] sum_q;
  logic err2_q;

  always_comb begin
    if (fwd1_q) begin
      old_val = fwd_data1_q;
    end else if (ent_vld1_q) begin
      old_val = rdata;
    end else begin
      old_val = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      sum_q <= '0;
    end else begin
      if (ld2) begin
        v2_q <= v1_q;
      end
      if (wr_en) begin
        sum_q <= sum_q - SumW'(old_val) + SumW'(val1_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld2 && v1_q) begin
      err2_q <= err1_q;
    end
  end

  // Stage 3: biased dividend sum * 16 + depth * 2^(NumW-1).
  logic signed [NumW-1:0] num;
  logic [MW-1:0] m3_q;
  logic err3_q;

  assign num = {sum_q, 4'b0000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ld3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3 && v2_q) begin
      m3_q <= $unsigned(MW'(num)) + Bias;
      err3_q <= err2_q;
    end
  end

  // Stage 4: multiplication by the reciprocal of the depth.
  logic [2*MW:0] prod4_q;
  logic err4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (ld4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld4 && v3_q) begin
      prod4_q <= m3_q * Recip;
      err4_q <= err3_q;
    end
  end

  // Output register: remove the bias from the quotient; zero on a read error.
  logic [AvgW-1:0] avg;
  logic [tsavg_pkg::OutDataW-1:0] odata_q;
  logic ouser_q;

  assign avg = prod4_q[K +: AvgW] - OutOff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ld_out) begin
      ov_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out && v4_q) begin
      odata_q <= err4_q ? '0 : tsavg_pkg::OutDataW'(avg);
      ouser_q <= err4_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = odata_q;
  assign m_axis_tuser = ouser_q;

  // The input side stalls only when the output holds an untaken result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled while the output register is free");

  // An error result never carries a mean.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("error result with nonzero data");

  // The write pointer stays inside the history.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= LastIdx)
    else $error("write pointer beyond the history depth");

  // A failed read leaves the write pointer in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser) |=> $stable(wp_q))
    else $error("write pointer moved on a read error");

endmodule

### sv/tsavg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tsavg_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### verif/tb.sv
// Self-checking testbench for the averaged one-wire temperature sensor core.
`timescale 1ns / 1ps

module tb;

  localparam int HIST_DEPTH = tsavg_pkg::HistDepthDef;
  localparam int RESET_CYCLES = 11;
  localparam int TAIL_CYCLES = 8;
  localparam int LONG_HOLD = 150;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 192;
  localparam logic [tsavg_pkg::PaddrW-1:0] ADDR_UNMAPPED = 3'd4;

  // One scratchpad read, packed with temp_lsb in the lowest byte.
  typedef struct packed {
    logic [7:0] count_per_degree;
    logic [7:0] count_remain;
    logic [7:0] resolution_byte;
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
  } scratch_t;

  typedef struct {
    logic [tsavg_pkg::AvgW-1:0] average_temp;
    logic                       error_flag;
  } avg_result_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [tsavg_pkg::PaddrW-1:0]   paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [tsavg_pkg::InDataW-1:0]  s_axis_tdata;
  logic                           s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [tsavg_pkg::OutDataW-1:0] m_axis_tdata;
  logic                           m_axis_tuser;

  // Receiver control; rx_idle_en and rx_hold are set by the stimulus process.
  bit rx_idle_en;
  int rx_hold;
  int rx_gap;

  // Scoreboard: tracks the history and running sum, holds expected means.
  class avg_scoreboard;
    avg_result_t                        expected_q[$];
    logic signed [tsavg_pkg::TempW-1:0] hist[HIST_DEPTH];
    int                                 wr_ptr;
    int                                 hist_sum;
    bit                                 nine_bit;
    int unsigned                        fails;

    function new();
      foreach (hist[i]) hist[i] = '0;
      wr_ptr = 0;
      hist_sum = 0;
      nine_bit = 1'b0;
      fails = 0;
    endfunction

    // Convert an accepted read and queue the mean, or error result, it should produce.
    function void note_read(scratch_t rd, logic err);
      logic [tsavg_pkg::TempW-1:0]        raw;
      logic signed [tsavg_pkg::TempW-1:0] temp16;
      avg_result_t                        res;
      int                                 num;
      int                                 quot;
      if (err) begin
        res.average_temp = '0;
        res.error_flag = 1'b1;
        expected_q.push_back(res);
        return;
      end
      raw = {rd.temp_msb, rd.temp_lsb};
      if (nine_bit) begin
        raw = raw << 3;
        if (rd.count_per_degree == tsavg_pkg::CountPerDegFine)
          raw = (raw & tsavg_pkg::FineMask) + tsavg_pkg::FineOffset
                - {8'h00, rd.count_remain};
      end else begin
        case (tsavg_pkg::res_sel_e'(rd.resolution_byte[6:5]))
          tsavg_pkg::RES_9BIT:  raw = raw << 3;
          tsavg_pkg::RES_10BIT: raw = raw << 2;
          tsavg_pkg::RES_11BIT: raw = raw << 1;
          default:              raw = raw;
        endcase
      end
      temp16 = raw;
      hist_sum = hist_sum - int'(hist[wr_ptr]) + int'(temp16);
      hist[wr_ptr] = temp16;
      wr_ptr = (wr_ptr + 1 >= HIST_DEPTH) ? 0 : wr_ptr + 1;
      // Mean in 1/256 degree, rounded toward minus infinity.
      num = hist_sum * 16;
      quot = num / HIST_DEPTH;
      if ((num % HIST_DEPTH) != 0 && num < 0) quot = quot - 1;
      res.average_temp = quot[tsavg_pkg::AvgW-1:0];
      res.error_flag = 1'b0;
      expected_q.push_back(res);
    endfunction

    // Compare one output transfer against the oldest expected mean.
    function void check_result(logic [tsavg_pkg::OutDataW-1:0] data, logic err);
      avg_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result average_temp=%h error_flag=%b",
                 $time, data[tsavg_pkg::AvgW-1:0], err);
        fails++;
        return;
      end
      want = expected_q.pop_front();
      if (data[tsavg_pkg::AvgW-1:0] !== want.average_temp) begin
        $display("%0t: average_temp expected %h actual %h",
                 $time, want.average_temp, data[tsavg_pkg::AvgW-1:0]);
        fails++;
      end
      if (err !== want.error_flag) begin
        $display("%0t: error_flag expected %b actual %b",
                 $time, want.error_flag, err);
        fails++;
      end
    endfunction
  endclass

  avg_scoreboard sb = new();

  temp_sensor_scratchpad_average_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("temp_sensor_scratchpad_average_core verification failed");
    $finish;
  end

  // Receiver: long hold-offs on request, else random stall bursts while enabled.
  initial begin
    m_axis_tready = 1'b0;
    rx_gap = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Check every output transfer.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  function automatic scratch_t make_scratch(logic [7:0] lsb, logic [7:0] msb,
                                            logic [7:0] res, logic [7:0] remain,
                                            logic [7:0] cpd);
    scratch_t rd;
    rd.temp_lsb = lsb;
    rd.temp_msb = msb;
    rd.resolution_byte = res;
    rd.count_remain = remain;
    rd.count_per_degree = cpd;
    return rd;
  endfunction

  // Mostly plausible temperatures, with fully random bytes mixed in.
  function automatic scratch_t random_scratch();
    scratch_t rd;
    rd.temp_lsb = 8'($urandom);
    case ($urandom_range(0, 3))
      0: rd.temp_msb = 8'h00;
      1: rd.temp_msb = 8'hFF;
      2: rd.temp_msb = 8'($urandom_range(0, 2)) ^ {8{$urandom_range(0, 1) == 1}};
      default: rd.temp_msb = 8'($urandom);
    endcase
    rd.resolution_byte = 8'($urandom);
    rd.count_remain = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, 16));
    rd.count_per_degree = ($urandom_range(0, 9) < 6) ? tsavg_pkg::CountPerDegFine
                                                     : 8'($urandom);
    return rd;
  endfunction

  // Offer one read and wait for its transfer.
  task automatic send_reading(input scratch_t rd, input logic err);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rd;
    s_axis_tuser <= err;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_read(rd, err);
  endtask

  // Hold the input side idle for a number of cycles.
  task automatic pause_input(input int cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Stop sending and let every outstanding result come out.
  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [tsavg_pkg::PaddrW-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the family register with random upper bits, then read it back.
  task automatic set_family(input bit fam);
    logic [31:0] wdata;
    logic [31:0] rdata;
    wdata = $urandom;
    wdata[0] = fam;
    apb_access(1'b1, tsavg_pkg::AddrFamily, wdata, rdata);
    sb.nine_bit = fam;
    apb_access(1'b0, tsavg_pkg::AddrFamily, 32'h0, rdata);
    if (rdata[0] !== fam) begin
      $display("%0t: family register expected %b actual %b", $time, fam, rdata[0]);
      sb.fails++;
    end
  endtask

  // One random phase; hold_at and pause_at mark the pressure points.
  task automatic run_phase(input bit idle, input int hold_at, input int pause_at);
    rx_idle_en = idle;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == hold_at) rx_hold = LONG_HOLD;
      if (i == pause_at) wait_results_drained();
      if (idle && $urandom_range(0, 5) == 0) pause_input($urandom_range(1, 19));
      send_reading(random_scratch(), $urandom_range(0, 9) == 0);
    end
  endtask

  // Main stimulus sequence.
  initial begin
    bit phase_fam[6];
    logic [31:0] unused_rd;
    phase_fam = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    rx_idle_en = 1'b1;
    rx_hold = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Resolution-field family: sign extremes, every shift, ignored bits.
    set_family(1'b0);
    send_reading(make_scratch(8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
    send_reading(make_scratch(8'hFF, 8'hFF, 8'h60, 8'h00, 8'h00), 1'b0);
    send_reading(make_scratch(8'h00, 8'h80, 8'h60, 8'h00, 8'h00), 1'b0);
    send_reading(make_scratch(8'hFF, 8'h7F, 8'h60, 8'h00, 8'h00), 1'b0);
    send_reading(make_scratch(8'h90, 8'h01, 8'h00, 8'h00, 8'h00), 1'b0);
    send_reading(make_scratch(8'h90, 8'h01, 8'h20, 8'h00, 8'h00), 1'b0);
    send_reading(make_scratch(8'h90, 8'h01, 8'h40, 8'h00, 8'h00), 1'b0);
    send_reading(make_scratch(8'h90, 8'h01, 8'h9F, 8'h00, 8'h00), 1'b0);
    send_reading(make_scratch(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0);
    send_reading(make_scratch(8'h12, 8'h34, 8'hE0, 8'hFF, 8'h10), 1'b0);
    send_reading(make_scratch(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1);
    send_reading(make_scratch(8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1);
    send_reading(make_scratch(8'h00, 8'h80, 8'h00, 8'h00, 8'h00), 1'b0);
    send_reading(make_scratch(8'hAA, 8'h55, 8'h20, 8'h00, 8'h00), 1'b0);
    wait_results_drained();

    // Nine-bit family: count-remain refinement, wrap, ignored config byte.
    set_family(1'b1);
    apb_access(1'b1, ADDR_UNMAPPED, 32'hFFFF_FFFE, unused_rd);
    send_reading(make_scratch(8'h32, 8'h00, 8'h00, 8'h0C, 8'h10), 1'b0);
    send_reading(make_scratch(8'h32, 8'h00, 8'h00, 8'h00, 8'h10), 1'b0);
    send_reading(make_scratch(8'h32, 8'h00, 8'h00, 8'hFF, 8'h10), 1'b0);
    send_reading(make_scratch(8'hCE, 8'hFF, 8'h00, 8'h05, 8'h10), 1'b0);
    send_reading(make_scratch(8'hFF, 8'hFF, 8'h60, 8'h10, 8'h0F), 1'b0);
    send_reading(make_scratch(8'hFF, 8'h0F, 8'h00, 8'h00, 8'h11), 1'b0);
    send_reading(make_scratch(8'h00, 8'h10, 8'h00, 8'h00, 8'h10), 1'b0);
    send_reading(make_scratch(8'h00, 8'h00, 8'h00, 8'h00, 8'h10), 1'b0);
    send_reading(make_scratch(8'hAA, 8'hAA, 8'h60, 8'h10, 8'h10), 1'b1);
    send_reading(make_scratch(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h10), 1'b0);
    send_reading(make_scratch(8'h00, 8'h80, 8'h00, 8'h00, 8'h10), 1'b0);
    wait_results_drained();

    // Random phases, each with its own family setting; the last one runs flat out.
    for (int p = 0; p < 6; p++) begin
      if (p == 0 || phase_fam[p] != phase_fam[p-1]) set_family(phase_fam[p]);
      run_phase(p < 5, (p == 1) ? 30 : -1, (p == 2) ? PHASE_ITEMS / 2 : -1);
      wait_results_drained();
    end

    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("temp_sensor_scratchpad_average_core verification clean");
    end else begin
      $display("temp_sensor_scratchpad_average_core verification failed");
    end
    $finish;
  end

endmodule
